@@ rtl/core/sfdd_pkg.sv @@
package sfdd_pkg;

	localparam int FRAME_W   = 24;
	localparam int TIME_W    = 32;
	localparam int CNT_W     = 5;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 24;

	localparam logic [CNT_W-1:0]  FRAME_LAST_BIT = 5'd23;
	localparam logic [TIME_W-1:0] WINDOW_RESET   = 32'd1000000;

	// frame queue between deframer and repeat filter
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;
	localparam logic [QCNT_W-1:0] QDEPTH_CNT = 2'd2;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [TIME_W-1:0]  stamp;
	} frame_entry_t;

endpackage

@@ rtl/core/sfdd_front.sv @@
module sfdd_front import sfdd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  bit_present,
	input  logic                  bit_follows,
	input  logic                  bit_value,
	input  logic [TIME_W-1:0]     time_us,
	output logic                  push,
	output frame_entry_t          push_entry
);

	logic [CNT_W-1:0]   bit_count_q;
	logic [FRAME_W-1:0] frame_shift_q;
	logic [CNT_W-1:0]   cnt_eff;
	logic [FRAME_W-1:0] shift_base;
	logic [FRAME_W-1:0] shift_next;
	logic               take;
	logic               done;

	always_comb begin
		take = accept & bit_present;
		// drop a partial frame when the burst breaks
		cnt_eff = (bit_count_q != '0 && !bit_follows) ? '0 : bit_count_q;
		shift_base = (cnt_eff == '0) ? '0 : frame_shift_q;
		shift_next = {shift_base[FRAME_W-2:0], bit_value};
		done = (cnt_eff == FRAME_LAST_BIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
		end else if (take) begin
			bit_count_q <= done ? '0 : cnt_eff + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_shift_q <= shift_next;
		end
	end

	assign push             = take & done;
	assign push_entry.frame = shift_next;
	assign push_entry.stamp = time_us;

endmodule

@@ rtl/core/sfdd_fifo.sv @@
module sfdd_fifo import sfdd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  frame_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output frame_entry_t head
);

	frame_entry_t      mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QDEPTH_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/sfdd_back.sv @@
module sfdd_back import sfdd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TIME_W-1:0]     cfg_data,
	input  logic                  q_empty,
	input  frame_entry_t          q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic [TIME_W-1:0]     window_q;
	logic [FRAME_W-1:0]    last_frame_q;
	logic [TIME_W-1:0]     last_time_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [TIME_W-1:0]     elapsed;
	logic                  emit;
	logic                  slot_free;
	logic [FRAME_W-1:0]    f;

	always_comb begin
		f         = q_head.frame;
		elapsed   = q_head.stamp - last_time_q;
		emit      = (f != last_frame_q) || (elapsed >= window_q);
		slot_free = !out_valid_q || out_ready;
		// a suppressed frame never waits for the output slot
		q_pop     = !q_empty && (!emit || slot_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RESET;
			last_frame_q <= '0;
			last_time_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_data;
			end
			if (q_pop) begin
				last_frame_q <= f;
				last_time_q  <= q_head.stamp;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			// tenths, whole, sign, status, id from high to low
			out_data_q <= {f[3:0], f[14:8], f[15], f[7:4], f[23:16]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/core/sensor_frame_deframer_dedup.sv @@
// Path: a frame's final bit beat is written into the frame queue, popped by the
// repeat filter and registered into the output slot before it shows on m_axis.
// Throughput: one input beat per cycle; a stalled output backs up a two-entry
// frame queue before s_axis_tready drops.
// Reset: arst_n clears bit count, last frame, last time and the queue, and
// loads the repeat window with 1000000 us.
module sensor_frame_deframer_dedup import sfdd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] bit_present, [1] bit_follows, [2] bit_value, [34:3] time_us, [39:35] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] sensor_id, [11:8] sensor_status, [12] temp_negative,
	// [19:13] temp_whole, [23:20] temp_tenths
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TIME_W-1:0]     cfg_data
);

	logic         accept;
	logic         push;
	frame_entry_t push_entry;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;
	frame_entry_t q_head;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign cfg_ready     = 1'b1;

	sfdd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.bit_present (s_axis_tdata[0]),
		.bit_follows (s_axis_tdata[1]),
		.bit_value   (s_axis_tdata[2]),
		.time_us     (s_axis_tdata[34:3]),
		.push        (push),
		.push_entry  (push_entry)
	);

	sfdd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	sfdd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
